// ----- sv/sgrd_pkg.sv -----
// Shared types, SGR codes and constants of the SGR attribute decoder.
`default_nettype none

package sgrd_pkg;

    // SGR parameter codes
    localparam logic [15:0] SGR_RESET      = 16'd0;
    localparam logic [15:0] SGR_BOLD       = 16'd1;
    localparam logic [15:0] SGR_DIM        = 16'd2;
    localparam logic [15:0] SGR_ITALIC     = 16'd3;
    localparam logic [15:0] SGR_UNDERLINE  = 16'd4;
    localparam logic [15:0] SGR_BLINK_SLOW = 16'd5;
    localparam logic [15:0] SGR_BLINK_FAST = 16'd6;
    localparam logic [15:0] SGR_INVERSE    = 16'd7;
    localparam logic [15:0] SGR_HIDDEN     = 16'd8;
    localparam logic [15:0] SGR_STRIKE     = 16'd9;
    localparam logic [15:0] SGR_DOUBLE_UL  = 16'd21;
    localparam logic [15:0] SGR_NO_WEIGHT  = 16'd22;
    localparam logic [15:0] SGR_NO_ITALIC  = 16'd23;
    localparam logic [15:0] SGR_NO_UL      = 16'd24;
    localparam logic [15:0] SGR_NO_BLINK   = 16'd25;
    localparam logic [15:0] SGR_NO_INVERSE = 16'd27;
    localparam logic [15:0] SGR_NO_HIDDEN  = 16'd28;
    localparam logic [15:0] SGR_NO_STRIKE  = 16'd29;
    localparam logic [15:0] SGR_EXT_FG     = 16'd38;
    localparam logic [15:0] SGR_EXT_BG     = 16'd48;
    localparam logic [15:0] SGR_EXT_UL     = 16'd58;
    localparam logic [15:0] SGR_FG_DEFAULT = 16'd39;
    localparam logic [15:0] SGR_BG_DEFAULT = 16'd49;
    localparam logic [15:0] SGR_FG_FIRST   = 16'd30;
    localparam logic [15:0] SGR_FG_LAST    = 16'd37;
    localparam logic [15:0] SGR_BG_FIRST   = 16'd40;
    localparam logic [15:0] SGR_BG_LAST    = 16'd47;
    localparam logic [15:0] SGR_FGB_FIRST  = 16'd90;
    localparam logic [15:0] SGR_FGB_LAST   = 16'd97;
    localparam logic [15:0] SGR_BGB_FIRST  = 16'd100;
    localparam logic [15:0] SGR_BGB_LAST   = 16'd107;
    localparam logic [15:0] COMP_MAX       = 16'd255;

    // Attribute flag masks
    localparam logic [8:0] A_BOLD   = 9'h001;
    localparam logic [8:0] A_DIM    = 9'h002;
    localparam logic [8:0] A_ITALIC = 9'h004;
    localparam logic [8:0] A_UL     = 9'h008;
    localparam logic [8:0] A_DUL    = 9'h010;
    localparam logic [8:0] A_BLINK  = 9'h020;
    localparam logic [8:0] A_INV    = 9'h040;
    localparam logic [8:0] A_HIDDEN = 9'h080;
    localparam logic [8:0] A_STRIKE = 9'h100;

    // Color kinds
    localparam logic [1:0] KIND_DEF = 2'd0;
    localparam logic [1:0] KIND_PAL = 2'd1;
    localparam logic [1:0] KIND_RGB = 2'd2;

    // Extended color targets
    localparam logic [1:0] TGT_FG = 2'd0;
    localparam logic [1:0] TGT_BG = 2'd1;
    localparam logic [1:0] TGT_UL = 2'd2;

    // Color space codes of a first subparameter
    localparam logic [2:0] CS_DEF   = 3'd0;
    localparam logic [2:0] CS_RGB   = 3'd2;
    localparam logic [2:0] CS_PAL   = 3'd5;
    localparam logic [2:0] CS_OTHER = 3'd7;

    // Subparameter count saturation
    localparam logic [2:0] SUB_MAX = 3'd7;

    // Result width of m_tdata
    localparam int OUT_W = 64;

    // Group operation decoded from a lead code
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_RESET  = 4'd1,
        OP_BITS   = 4'd2,
        OP_UL     = 4'd3,
        OP_FG_DEF = 4'd4,
        OP_BG_DEF = 4'd5,
        OP_FG_PAL = 4'd6,
        OP_BG_PAL = 4'd7,
        OP_EXT    = 4'd8
    } op_t;

    // Extended color parse phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SPACE = 4'b0010,
        PH_INDEX = 4'b0100,
        PH_RGB   = 4'b1000
    } ph_t;

    typedef struct packed {
        op_t        op;
        logic [8:0] set_m;
        logic [8:0] clr_m;
        logic [3:0] idx;
        logic       bright;
        logic [1:0] tgt;
    } cls_t;

    // One classified request as held in the queue
    typedef struct packed {
        cls_t       cls;
        logic [7:0] clamp;
        logic [2:0] space;
        logic       sub;
        logic       last;
    } q_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic pop;
        logic last;
    } bk_stat_t;

endpackage

`default_nettype wire

// ----- sv/sgrd_front.sv -----
// Front end: accepts parameter requests and classifies them for the back end.
`default_nettype none

module sgrd_front
    import sgrd_pkg::*;
(
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] param_value
    input  wire logic    s_tuser,       // [0] is_subparam
    input  wire logic    s_tlast,       // last_param
    input  wire q_stat_t q_stat,
    output logic         push,
    output q_item_t      item
);

    // Decode a lead code into the operation its group performs on close
    function automatic cls_t classify(logic [15:0] v);
        cls_t        c;
        logic [15:0] d_fg;
        logic [15:0] d_bg;
        logic [15:0] d_fgb;
        logic [15:0] d_bgb;
        d_fg  = v - SGR_FG_FIRST;
        d_bg  = v - SGR_BG_FIRST;
        d_fgb = v - SGR_FGB_FIRST;
        d_bgb = v - SGR_BGB_FIRST;
        c = '0;
        c.op = OP_NONE;
        unique case (v)
            SGR_RESET:      c.op = OP_RESET;
            SGR_BOLD:       begin c.op = OP_BITS; c.set_m = A_BOLD;   end
            SGR_DIM:        begin c.op = OP_BITS; c.set_m = A_DIM;    end
            SGR_ITALIC:     begin c.op = OP_BITS; c.set_m = A_ITALIC; end
            SGR_UNDERLINE:  c.op = OP_UL;
            SGR_BLINK_SLOW,
            SGR_BLINK_FAST: begin c.op = OP_BITS; c.set_m = A_BLINK;  end
            SGR_INVERSE:    begin c.op = OP_BITS; c.set_m = A_INV;    end
            SGR_HIDDEN:     begin c.op = OP_BITS; c.set_m = A_HIDDEN; end
            SGR_STRIKE:     begin c.op = OP_BITS; c.set_m = A_STRIKE; end
            SGR_DOUBLE_UL:  begin c.op = OP_BITS; c.set_m = A_DUL; c.clr_m = A_UL; end
            SGR_NO_WEIGHT:  begin c.op = OP_BITS; c.clr_m = A_BOLD | A_DIM; end
            SGR_NO_ITALIC:  begin c.op = OP_BITS; c.clr_m = A_ITALIC; end
            SGR_NO_UL:      begin c.op = OP_BITS; c.clr_m = A_UL | A_DUL; end
            SGR_NO_BLINK:   begin c.op = OP_BITS; c.clr_m = A_BLINK;  end
            SGR_NO_INVERSE: begin c.op = OP_BITS; c.clr_m = A_INV;    end
            SGR_NO_HIDDEN:  begin c.op = OP_BITS; c.clr_m = A_HIDDEN; end
            SGR_NO_STRIKE:  begin c.op = OP_BITS; c.clr_m = A_STRIKE; end
            SGR_FG_DEFAULT: c.op = OP_FG_DEF;
            SGR_BG_DEFAULT: c.op = OP_BG_DEF;
            SGR_EXT_FG:     begin c.op = OP_EXT; c.tgt = TGT_FG; end
            SGR_EXT_BG:     begin c.op = OP_EXT; c.tgt = TGT_BG; end
            SGR_EXT_UL:     begin c.op = OP_EXT; c.tgt = TGT_UL; end
            default: begin
                // basic and bright palette ranges
                if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST) begin
                    c.op = OP_FG_PAL; c.idx = {1'b0, d_fg[2:0]}; c.bright = 1'b1;
                end else if (v >= SGR_BG_FIRST && v <= SGR_BG_LAST) begin
                    c.op = OP_BG_PAL; c.idx = {1'b0, d_bg[2:0]};
                end else if (v >= SGR_FGB_FIRST && v <= SGR_FGB_LAST) begin
                    c.op = OP_FG_PAL; c.idx = {1'b1, d_fgb[2:0]};
                end else if (v >= SGR_BGB_FIRST && v <= SGR_BGB_LAST) begin
                    c.op = OP_BG_PAL; c.idx = {1'b1, d_bgb[2:0]};
                end
            end
        endcase
        return c;
    endfunction

    // Handshake: take a request whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // Classification of the incoming parameter
    always_comb begin
        item.cls   = classify(s_tdata);
        item.clamp = (s_tdata > COMP_MAX) ? 8'hFF : s_tdata[7:0];
        if (s_tdata == 16'(CS_DEF) || s_tdata == 16'(CS_RGB) || s_tdata == 16'(CS_PAL)) begin
            item.space = s_tdata[2:0];
        end else begin
            item.space = CS_OTHER;
        end
        item.sub  = s_tuser;
        item.last = s_tlast;
    end

endmodule

`default_nettype wire

// ----- sv/sgrd_queue.sv -----
// Short request queue between the front and back ends.
`default_nettype none

module sgrd_queue
    import sgrd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire q_item_t wr_item,
    input  wire logic    pop,
    output q_item_t      rd_item,
    output q_stat_t      stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_item_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage slots
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item    = slot_reg[rd_ptr_reg];
    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ----- sv/sgrd_back.sv -----
// Back end: applies classified parameters to the style state and emits results.
`default_nettype none

module sgrd_back
    import sgrd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire q_item_t item,
    input  wire q_stat_t q_stat,
    output logic         pop,
    output bk_stat_t     bk_stat,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic [3:0]   m_tuser
);

    typedef struct packed {
        logic [8:0]      attr;
        logic [1:0]      fk;
        logic [23:0]     fc;
        logic [1:0]      bk;
        logic [23:0]     bc;
        ph_t             ph;
        logic [1:0]      tgt;
        logic [1:0]      left;
        logic [2:0]      csc;
        logic [2:0][7:0] win;
        cls_t            lead;
        logic [2:0]      cnt;
        logic            gopen;
        logic            skip;
    } st_t;

    st_t              st_reg, st_next, s;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic [3:0]       m_user_reg, m_user_next;

    // State after reset: everything clear, parser idle
    function automatic st_t reset_state();
        st_t r;
        r    = '0;
        r.ph = PH_IDLE;
        return r;
    endfunction

    // Color write; the underline target is dropped
    function automatic st_t set_color(st_t x, logic [1:0] tgt, logic [1:0] kind,
                                      logic [23:0] val);
        st_t r;
        r = x;
        if (tgt == TGT_FG) begin
            r.fk = kind;
            r.fc = val;
        end else if (tgt == TGT_BG) begin
            r.bk = kind;
            r.bc = val;
        end
        return r;
    endfunction

    function automatic st_t shift_win(st_t x, logic [7:0] c);
        st_t r;
        r = x;
        r.win[0] = x.win[1];
        r.win[1] = x.win[2];
        r.win[2] = c;
        return r;
    endfunction

    // Apply the open group's operation
    function automatic st_t close_group(st_t x, logic more);
        st_t        r;
        logic [3:0] pidx;
        r = x;
        pidx = {x.lead.idx[3] | (x.lead.bright & x.attr[0]), x.lead.idx[2:0]};
        unique case (x.lead.op)
            OP_RESET: begin
                r.attr = '0;
                r.fk   = KIND_DEF;
                r.fc   = '0;
                r.bk   = KIND_DEF;
                r.bc   = '0;
            end
            OP_BITS: r.attr = (x.attr & ~x.lead.clr_m) | x.lead.set_m;
            OP_UL: begin
                if (x.cnt != '0 && x.csc == CS_DEF) begin
                    r.attr = x.attr & ~(A_UL | A_DUL);
                end else if (x.cnt != '0 && x.csc == CS_RGB) begin
                    r.attr = (x.attr & ~A_UL) | A_DUL;
                end else begin
                    r.attr = (x.attr & ~A_DUL) | A_UL;
                end
            end
            OP_FG_DEF: begin r.fk = KIND_DEF; r.fc = '0; end
            OP_BG_DEF: begin r.bk = KIND_DEF; r.bc = '0; end
            OP_FG_PAL: r = set_color(x, TGT_FG, KIND_PAL, {20'd0, pidx});
            OP_BG_PAL: r = set_color(x, TGT_BG, KIND_PAL, {20'd0, x.lead.idx});
            OP_EXT: begin
                if (x.cnt != '0) begin
                    // colon form
                    if (x.csc == CS_PAL && x.cnt >= 3'd2) begin
                        r = set_color(x, x.lead.tgt, KIND_PAL, {16'd0, x.win[0]});
                    end else if (x.csc == CS_RGB && x.cnt >= 3'd4) begin
                        r = set_color(x, x.lead.tgt, KIND_RGB,
                                      {x.win[0], x.win[1], x.win[2]});
                    end
                end else if (more) begin
                    // semicolon form: following groups carry the color
                    r.ph   = PH_SPACE;
                    r.tgt  = x.lead.tgt;
                    r.left = '0;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Semicolon form: lead value of a group taken as a color operand
    function automatic st_t consume(st_t x, q_item_t it);
        st_t r;
        r = x;
        unique case (x.ph)
            PH_SPACE: begin
                if (it.space == CS_PAL) begin
                    r.ph = PH_INDEX;
                end else if (it.space == CS_RGB) begin
                    r.ph   = PH_RGB;
                    r.left = 2'd3;
                end else begin
                    r.ph = PH_IDLE;
                end
            end
            PH_INDEX: begin
                r    = set_color(x, x.tgt, KIND_PAL, {16'd0, it.clamp});
                r.ph = PH_IDLE;
            end
            default: begin
                r      = shift_win(x, it.clamp);
                r.left = x.left - 1'b1;
                if (r.left == '0) begin
                    r    = set_color(r, x.tgt, KIND_RGB, {r.win[0], r.win[1], r.win[2]});
                    r.ph = PH_IDLE;
                end
            end
        endcase
        return r;
    endfunction

    // Pop: items without a result never wait on the output register
    assign pop          = q_stat.valid && (!item.last || !m_valid_reg || m_tready);
    assign bk_stat.pop  = pop;
    assign bk_stat.last = item.last;

    // Per-request state update
    always_comb begin
        s = st_reg;
        if (item.sub && s.gopen) begin
            if (!s.skip) begin
                if (s.cnt == '0) begin
                    s.csc = item.space;
                end else if (s.csc == CS_PAL) begin
                    if (s.cnt == 3'd1) begin
                        s.win[0] = item.clamp;
                    end
                end else if (s.csc == CS_RGB) begin
                    s = shift_win(s, item.clamp);
                end
                if (s.cnt != SUB_MAX) begin
                    s.cnt = s.cnt + 1'b1;
                end
            end
        end else begin
            if (s.gopen && !s.skip) begin
                s = close_group(s, 1'b1);
            end
            if (s.ph != PH_IDLE) begin
                s.skip = 1'b1;
                s = consume(s, item);
            end else begin
                s.skip = 1'b0;
                s.lead = item.cls;
                s.cnt  = '0;
                s.csc  = CS_DEF;
            end
            s.gopen = 1'b1;
        end
        if (item.last) begin
            if (s.gopen && !s.skip) begin
                s = close_group(s, 1'b0);
            end
            s.ph    = PH_IDLE;
            s.left  = '0;
            s.gopen = 1'b0;
            s.skip  = 1'b0;
        end
        st_next = pop ? s : st_reg;
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (pop && item.last) begin
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, s.bc, s.fc, s.attr};
            m_user_next  = {s.bk, s.fk};
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= reset_state();
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- sv/sgr_style_attribute_decoder_top.sv -----
// Top level of the SGR style attribute decoder.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata param_value, tuser is_subparam, tlast
//  m_      | out | m_tvalid/m_tready  | tdata attr, fg value, bg value; tuser kinds
//
// One parameter per cycle is taken and applied while s_tready is high; the back
// end's state update sets that rate. A style appears on m_ after the final
// parameter is taken: it is written to a queue slot, then popped and registered.
// Reset clears the style to defaults and empties the queue. While m_tvalid is
// high and m_tready low, non-final parameters keep draining; a final parameter
// waits in the queue of QUEUE_DEPTH entries and s_tready drops when it is full.
`default_nettype none

module sgr_style_attribute_decoder_top
    import sgrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [15:0] param_value
    input  wire logic        s_tuser,  // [0] is_subparam
    input  wire logic        s_tlast,  // last_param
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [OUT_W-1:0] m_tdata,  // [8:0] attr_flags, [32:9] fg_value,
                                       // [56:33] bg_value, [63:57] zero
    output logic [3:0]       m_tuser   // [1:0] fg_kind, [3:2] bg_kind
);

    q_stat_t  q_stat;
    bk_stat_t bk_stat;
    q_item_t  wr_item, rd_item;
    logic     push, pop;

    sgrd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .item     (wr_item)
    );

    sgrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (q_stat)
    );

    sgrd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (rd_item),
        .q_stat   (q_stat),
        .pop      (pop),
        .bk_stat  (bk_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A result only appears after a final parameter left the queue
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(bk_stat.pop && bk_stat.last))
        else $error("result without a final parameter");

    // The back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        bk_stat.pop |-> q_stat.valid)
        else $error("pop from empty queue");

    // Color kinds stay within default, palette and rgb
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] <= KIND_RGB && m_tuser[3:2] <= KIND_RGB))
        else $error("invalid color kind");

    // Foreground palette colors carry an 8-bit index
    a_palette_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1:0] == KIND_PAL) |-> (m_tdata[32:17] == 16'd0))
        else $error("palette index out of range");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench of the SGR style attribute decoder: random and directed streams.
module tb_top
    import sgrd_pkg::*;
();

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int IDLE_PCT     = 19;
    localparam logic [23:0] BRIGHT_OFS = 24'd8;
    localparam logic [15:0] SPACE_RGB  = 16'(CS_RGB);
    localparam logic [15:0] SPACE_PAL  = 16'(CS_PAL);

    typedef struct packed {
        logic [8:0]  attr;
        logic [1:0]  fg_kind;
        logic [23:0] fg_val;
        logic [1:0]  bg_kind;
        logic [23:0] bg_val;
    } style_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata  = '0;    // [15:0] param_value
    logic             s_tuser  = 1'b0;  // [0] is_subparam
    logic             s_tlast  = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // [8:0] attr_flags, [32:9] fg_value,
                                        // [56:33] bg_value
    logic [3:0]       m_tuser;          // [1:0] fg_kind, [3:2] bg_kind

    style_t style_q[$];
    int     err_count  = 0;
    int     items_sent = 0;
    bit     no_gaps    = 1'b0;
    bit     hold_req   = 1'b0;

    // Shadow of the decoder's style and parse state
    logic [8:0]  st_attr;
    logic [1:0]  st_fg_kind;
    logic [1:0]  st_bg_kind;
    logic [23:0] st_fg_val;
    logic [23:0] st_bg_val;
    ph_t         xc_phase;
    logic [1:0]  xc_tgt;
    logic [1:0]  xc_left;
    logic [2:0]  grp_space;
    logic [7:0]  grp_comp [3];
    logic [15:0] grp_lead;
    logic [2:0]  grp_subs;
    bit          grp_open;
    bit          grp_skip;

    sgr_style_attribute_decoder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [7:0] sat8(input logic [15:0] v);
        return (v > COMP_MAX) ? COMP_MAX[7:0] : v[7:0];
    endfunction

    function automatic void shift_comp(input logic [15:0] v);
        grp_comp[0] = grp_comp[1];
        grp_comp[1] = grp_comp[2];
        grp_comp[2] = sat8(v);
    endfunction

    // underline color target is accepted and dropped
    function automatic void paint(input logic [1:0] tgt, input logic [1:0] kind,
                                  input logic [23:0] val);
        if (tgt == TGT_FG) begin
            st_fg_kind = kind;
            st_fg_val  = val;
        end else if (tgt == TGT_BG) begin
            st_bg_kind = kind;
            st_bg_val  = val;
        end
    endfunction

    function automatic void modify_attr(input logic [8:0] set_m, input logic [8:0] clr_m);
        st_attr = (st_attr & ~clr_m) | set_m;
    endfunction

    // A group takes effect when it closes
    function automatic void close_group(input bit more);
        logic [1:0]  tgt;
        logic [23:0] bright;
        bright = ((st_attr & A_BOLD) != 0) ? BRIGHT_OFS : 24'd0;
        case (grp_lead)
            SGR_RESET: begin
                st_attr = '0;
                paint(TGT_FG, KIND_DEF, '0);
                paint(TGT_BG, KIND_DEF, '0);
            end
            SGR_BOLD:   modify_attr(A_BOLD, '0);
            SGR_DIM:    modify_attr(A_DIM, '0);
            SGR_ITALIC: modify_attr(A_ITALIC, '0);
            SGR_UNDERLINE: begin
                if (grp_subs != 0 && grp_space == CS_DEF)
                    modify_attr('0, A_UL | A_DUL);
                else if (grp_subs != 0 && grp_space == CS_RGB)
                    modify_attr(A_DUL, A_UL);
                else
                    modify_attr(A_UL, A_DUL);
            end
            SGR_BLINK_SLOW, SGR_BLINK_FAST: modify_attr(A_BLINK, '0);
            SGR_INVERSE:    modify_attr(A_INV, '0);
            SGR_HIDDEN:     modify_attr(A_HIDDEN, '0);
            SGR_STRIKE:     modify_attr(A_STRIKE, '0);
            SGR_DOUBLE_UL:  modify_attr(A_DUL, A_UL);
            SGR_NO_WEIGHT:  modify_attr('0, A_BOLD | A_DIM);
            SGR_NO_ITALIC:  modify_attr('0, A_ITALIC);
            SGR_NO_UL:      modify_attr('0, A_UL | A_DUL);
            SGR_NO_BLINK:   modify_attr('0, A_BLINK);
            SGR_NO_INVERSE: modify_attr('0, A_INV);
            SGR_NO_HIDDEN:  modify_attr('0, A_HIDDEN);
            SGR_NO_STRIKE:  modify_attr('0, A_STRIKE);
            SGR_FG_DEFAULT: paint(TGT_FG, KIND_DEF, '0);
            SGR_BG_DEFAULT: paint(TGT_BG, KIND_DEF, '0);
            SGR_EXT_FG, SGR_EXT_BG, SGR_EXT_UL: begin
                tgt = (grp_lead == SGR_EXT_FG) ? TGT_FG :
                      (grp_lead == SGR_EXT_BG) ? TGT_BG : TGT_UL;
                if (grp_subs != 0) begin
                    // colon form: everything came as subparameters
                    if (grp_space == CS_PAL && grp_subs >= 2)
                        paint(tgt, KIND_PAL, {16'd0, grp_comp[0]});
                    else if (grp_space == CS_RGB && grp_subs >= 4)
                        paint(tgt, KIND_RGB, {grp_comp[0], grp_comp[1], grp_comp[2]});
                end else if (more) begin
                    // semicolon form: following groups carry the color
                    xc_phase = PH_SPACE;
                    xc_tgt   = tgt;
                    xc_left  = '0;
                end
            end
            default: begin
                if (grp_lead >= SGR_FG_FIRST && grp_lead <= SGR_FG_LAST)
                    paint(TGT_FG, KIND_PAL, 24'(grp_lead - SGR_FG_FIRST) + bright);
                else if (grp_lead >= SGR_BG_FIRST && grp_lead <= SGR_BG_LAST)
                    paint(TGT_BG, KIND_PAL, 24'(grp_lead - SGR_BG_FIRST));
                else if (grp_lead >= SGR_FGB_FIRST && grp_lead <= SGR_FGB_LAST)
                    paint(TGT_FG, KIND_PAL, 24'(grp_lead - SGR_FGB_FIRST) + BRIGHT_OFS);
                else if (grp_lead >= SGR_BGB_FIRST && grp_lead <= SGR_BGB_LAST)
                    paint(TGT_BG, KIND_PAL, 24'(grp_lead - SGR_BGB_FIRST) + BRIGHT_OFS);
            end
        endcase
    endfunction

    // Lead value of a group swallowed by a semicolon-form extended color
    function automatic void consume_ext(input logic [15:0] v);
        case (xc_phase)
            PH_SPACE: begin
                if (v == SPACE_PAL) begin
                    xc_phase = PH_INDEX;
                end else if (v == SPACE_RGB) begin
                    xc_phase = PH_RGB;
                    xc_left  = 2'd3;
                end else begin
                    xc_phase = PH_IDLE;
                end
            end
            PH_INDEX: begin
                paint(xc_tgt, KIND_PAL, {16'd0, sat8(v)});
                xc_phase = PH_IDLE;
            end
            default: begin
                shift_comp(v);
                xc_left = xc_left - 2'd1;
                if (xc_left == 0) begin
                    paint(xc_tgt, KIND_RGB, {grp_comp[0], grp_comp[1], grp_comp[2]});
                    xc_phase = PH_IDLE;
                end
            end
        endcase
    endfunction

    // Apply one accepted parameter; returns 1 with the style when one is emitted
    function automatic bit apply_param(input logic [15:0] v, input logic sub,
                                       input logic last, output style_t s);
        s = '0;
        if (sub && grp_open) begin
            if (!grp_skip) begin
                if (grp_subs == 0)
                    grp_space = (v == 16'(CS_DEF) || v == SPACE_RGB || v == SPACE_PAL) ?
                                v[2:0] : CS_OTHER;
                else if (grp_space == CS_PAL) begin
                    if (grp_subs == 1) grp_comp[0] = sat8(v);
                end else if (grp_space == CS_RGB)
                    shift_comp(v);
                if (grp_subs < SUB_MAX) grp_subs = grp_subs + 3'd1;
            end
        end else begin
            if (grp_open && !grp_skip) close_group(1'b1);
            if (xc_phase != PH_IDLE) begin
                grp_skip = 1'b1;
                consume_ext(v);
            end else begin
                grp_skip  = 1'b0;
                grp_lead  = v;
                grp_subs  = '0;
                grp_space = CS_DEF;
            end
            grp_open = 1'b1;
        end
        if (!last) return 1'b0;
        if (grp_open && !grp_skip) close_group(1'b0);
        xc_phase = PH_IDLE;
        xc_left  = '0;
        grp_open = 1'b0;
        grp_skip = 1'b0;
        s = '{st_attr, st_fg_kind, st_fg_val, st_bg_kind, st_bg_val};
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- stimulus

    task automatic send_param(input logic [15:0] v, input logic sub, input logic last);
        style_t s;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= sub;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (apply_param(v, sub, last, s)) style_q = {style_q, s};
        items_sent++;
    endtask

    function automatic logic [15:0] rand_param();
        return 16'($urandom_range(0, 65535));
    endfunction

    // color component, weighted toward the clamp boundary
    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return COMP_MAX;
            2:       return COMP_MAX + 16'd1;
            3:       return 16'hFFFF;
            4:       return 16'($urandom_range(256, 65535));
            default: return 16'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 10))
            0: return SGR_FG_FIRST + 16'($urandom_range(0, 7));
            1: return SGR_BG_FIRST + 16'($urandom_range(0, 7));
            2: return SGR_FGB_FIRST + 16'($urandom_range(0, 7));
            3: return SGR_BGB_FIRST + 16'($urandom_range(0, 7));
            4: return 16'($urandom_range(SGR_RESET, SGR_STRIKE));
            5: return 16'($urandom_range(SGR_DOUBLE_UL, SGR_NO_STRIKE));
            6: return ($urandom_range(0, 1) != 0) ? SGR_FG_DEFAULT : SGR_BG_DEFAULT;
            7: return SGR_BOLD;
            8: return SGR_UNDERLINE;
            9: return SGR_RESET;
            default: return 16'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [15:0] pick_ext();
        case ($urandom_range(0, 2))
            0:       return SGR_EXT_FG;
            1:       return SGR_EXT_BG;
            default: return SGR_EXT_UL;
        endcase
    endfunction

    function automatic logic [15:0] pick_space();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return SPACE_RGB;
        if (r < 8) return SPACE_PAL;
        return rand_param();
    endfunction

    // One escape sequence: mostly well-formed groups, some noise
    task automatic send_random_sgr();
        logic [15:0] vals[$];
        bit          subs[$];
        logic [15:0] space;
        int          groups;
        int          pick;
        int          cnt;
        groups = $urandom_range(1, 6);
        for (int g = 0; g < groups; g++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                vals = {vals, pick_code()};
                subs = {subs, 1'b0};
                if (vals[$] == SGR_UNDERLINE && $urandom_range(0, 1) != 0) begin
                    vals = {vals, 16'($urandom_range(0, 5))};
                    subs = {subs, 1'b1};
                end else if ($urandom_range(0, 9) == 0) begin
                    vals = {vals, rand_param()};
                    subs = {subs, 1'b1};
                end
            end else if (pick < 60) begin
                // semicolon form
                space = pick_space();
                vals = {vals, pick_ext()};
                subs = {subs, 1'b0};
                vals = {vals, space};
                subs = {subs, 1'b0};
                cnt = (space == SPACE_RGB) ? 3 : (space == SPACE_PAL) ? 1 : 0;
                if ($urandom_range(0, 9) == 0) cnt = $urandom_range(0, cnt);
                repeat (cnt) begin
                    vals = {vals, rand_comp()};
                    subs = {subs, 1'b0};
                    if ($urandom_range(0, 9) == 0) begin
                        vals = {vals, rand_param()};
                        subs = {subs, 1'b1};
                    end
                end
            end else if (pick < 80) begin
                // colon form
                space = pick_space();
                vals = {vals, pick_ext()};
                subs = {subs, 1'b0};
                vals = {vals, space};
                subs = {subs, 1'b1};
                if (space == SPACE_RGB)
                    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
                                                        $urandom_range(3, 7);
                else if (space == SPACE_PAL)
                    cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
                else
                    cnt = $urandom_range(0, 2);
                repeat (cnt) begin
                    vals = {vals, rand_comp()};
                    subs = {subs, 1'b1};
                end
            end else begin
                // noise, leading subparameters included
                repeat ($urandom_range(1, 3)) begin
                    vals = {vals, rand_param()};
                    subs = {subs, bit'($urandom_range(0, 1) != 0)};
                end
            end
        end
        for (int i = 0; i < vals.size(); i++)
            send_param(vals[i], subs[i], i == vals.size() - 1);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // leading subparameter opens a group; 4:2 is double underline
        send_param(SGR_UNDERLINE, 1'b1, 1'b0);
        send_param(16'(CS_RGB), 1'b1, 1'b1);
        // 4:0 clears both underlines
        send_param(SGR_UNDERLINE, 1'b0, 1'b0);
        send_param(16'(CS_DEF), 1'b1, 1'b1);
        // bold makes basic foreground bright; 21 double underline
        send_param(SGR_BOLD, 1'b0, 1'b0);
        send_param(SGR_FG_FIRST + 16'd1, 1'b0, 1'b0);
        send_param(SGR_DOUBLE_UL, 1'b0, 1'b1);
        // semicolon palette with clamped index
        send_param(SGR_EXT_FG, 1'b0, 1'b0);
        send_param(SPACE_PAL, 1'b0, 1'b0);
        send_param(16'hFFFF, 1'b0, 1'b1);
        // colon rgb with empty id field and clamped components
        send_param(SGR_EXT_BG, 1'b0, 1'b0);
        send_param(SPACE_RGB, 1'b1, 1'b0);
        send_param(16'd0, 1'b1, 1'b0);
        send_param(16'd300, 1'b1, 1'b0);
        send_param(16'd7, 1'b1, 1'b0);
        send_param(16'hFFFF, 1'b1, 1'b1);
        // underline color cut off by end of sequence
        send_param(SGR_EXT_UL, 1'b0, 1'b0);
        send_param(SPACE_RGB, 1'b0, 1'b0);
        send_param(16'd1, 1'b0, 1'b0);
        send_param(16'd2, 1'b0, 1'b1);
        // colon rgb with too few components leaves color alone
        send_param(SGR_EXT_FG, 1'b0, 1'b0);
        send_param(SPACE_RGB, 1'b1, 1'b0);
        send_param(16'd1, 1'b1, 1'b0);
        send_param(16'd2, 1'b1, 1'b1);
        // full reset
        send_param(SGR_RESET, 1'b0, 1'b1);
    endtask

    task automatic test_random(input int upto);
        while (items_sent < upto) send_random_sgr();
    endtask

    // neither side idles
    task automatic test_streaming(input int upto);
        no_gaps = 1'b1;
        test_random(upto);
        no_gaps = 1'b0;
    endtask

    // sink stalls long while short sequences keep coming
    task automatic test_backpressure();
        no_gaps  = 1'b1;
        hold_req = 1'b1;
        repeat (24) begin
            send_param(pick_code(), 1'b0, 1'b0);
            send_param(pick_code(), 1'b0, 1'b1);
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_style(input logic [OUT_W-1:0] d, input logic [3:0] u);
        style_t e;
        if (style_q.size() == 0) begin
            $error("unexpected style %0h", d);
            err_count++;
            return;
        end
        e = style_q.pop_front();
        if (d[8:0] !== e.attr) begin
            $error("attr_flags: expected %0h, got %0h", e.attr, d[8:0]);
            err_count++;
        end
        if (u[1:0] !== e.fg_kind) begin
            $error("fg_kind: expected %0d, got %0d", e.fg_kind, u[1:0]);
            err_count++;
        end
        if (d[32:9] !== e.fg_val) begin
            $error("fg_value: expected %0h, got %0h", e.fg_val, d[32:9]);
            err_count++;
        end
        if (u[3:2] !== e.bg_kind) begin
            $error("bg_kind: expected %0d, got %0d", e.bg_kind, u[3:2]);
            err_count++;
        end
        if (d[56:33] !== e.bg_val) begin
            $error("bg_value: expected %0h, got %0h", e.bg_val, d[56:33]);
            err_count++;
        end
    endfunction

    // result sink: checks, random ready, one long hold-off on request
    initial begin : style_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) check_style(m_tdata, m_tuser);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // no request moving on either side for too long
    initial begin : watchdog
        int stalls;
        stalls = 0;
        while (stalls < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stalls = 0;
            else
                stalls++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin : main
        st_attr    = '0;
        st_fg_kind = KIND_DEF;
        st_bg_kind = KIND_DEF;
        st_fg_val  = '0;
        st_bg_val  = '0;
        xc_phase   = PH_IDLE;
        xc_tgt     = '0;
        xc_left    = '0;
        grp_space  = CS_DEF;
        grp_comp   = '{8'd0, 8'd0, 8'd0};
        grp_lead   = '0;
        grp_subs   = '0;
        grp_open   = 1'b0;
        grp_skip   = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(400);
        test_streaming(600);
        test_backpressure();
        test_random(950);
        s_tvalid <= 1'b0;

        while (style_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- files.f -----
sv/sgrd_pkg.sv
sv/sgrd_front.sv
sv/sgrd_queue.sv
sv/sgrd_back.sv
sv/sgr_style_attribute_decoder_top.sv
dv/tb_top.sv
